[rtl/ppl_pkg.sv]
// shared constants and types of the position pd loop
package ppl_pkg;

    // default sizes of the angle and of the multi-turn position
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 32;

    // fixed field widths
    localparam int TARGET_W   = 32;
    localparam int CMD_W      = 16;
    localparam int POS_OUT_W  = 32;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int FRAC_BITS  = 8;

    // error and error change are capped to +-2^40 before the products
    localparam int CAP_W      = 42;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REVERSE_DIRECTION = 2'd0,
        CFG_PROP_GAIN         = 2'd1,
        CFG_DERIV_GAIN        = 2'd2,
        CFG_OUT_LIMIT         = 2'd3
    } t_cfg_idx;

endpackage

[rtl/position_pd_loop.sv]
// position pd controller with angle unwrap and output saturation
//
//  channel   direction  payload (low bits first)                  handshake
//  s_axis    in         tdata: angle, target_pos, zero pad        tvalid/tready
//  m_axis    out        tdata: speed_cmd, position; tuser: limited tvalid/tready
//  cfg       in         i_cfg_addr, i_cfg_wdata                   i_cfg_we
//
// Three register stages: position/error update, gain multipliers, sum with
// rounding and clamp. One sample is taken every cycle unless m_axis stalls.
// Position and error history update in the first stage as a sample is taken.
// Synchronous active-low reset clears state, gains and limit.
// A stalled m_axis holds all stages and drops s_axis_tready.
module position_pd_loop #(
    parameter int ANGLE_BITS    = ppl_pkg::ANGLE_BITS_DEF,
    parameter int POSITION_BITS = ppl_pkg::POSITION_BITS_DEF,
    parameter int IN_DATA_W     = ((ANGLE_BITS + ppl_pkg::TARGET_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [ppl_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ppl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // sample stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_DATA_W-1:0]           s_axis_tdata,  // angle, target_pos, pad
    // command stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [47:0]                    m_axis_tdata,  // speed_cmd, position
    output logic [0:0]                     m_axis_tuser   // limited
);

    localparam int AW      = ANGLE_BITS;
    localparam int PW      = POSITION_BITS;
    localparam int ERR_W   = ((PW > ppl_pkg::TARGET_W) ? PW : ppl_pkg::TARGET_W) + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int EXT_W   = (DIFF_W > ppl_pkg::CAP_W) ? DIFF_W : ppl_pkg::CAP_W;
    localparam int PROD_W  = ppl_pkg::GAIN_W + ppl_pkg::CAP_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int TW      = ppl_pkg::TARGET_W;
    localparam int CW      = ppl_pkg::CMD_W;
    localparam int OW      = ppl_pkg::POS_OUT_W;
    localparam int LW      = ppl_pkg::LIMIT_W;
    localparam int FB      = ppl_pkg::FRAC_BITS;

    localparam logic signed [AW+1:0]    HALF   = (AW+2)'(1) << (AW - 1);
    localparam logic signed [AW+1:0]    FULL   = (AW+2)'(1) << AW;
    localparam logic signed [EXT_W-1:0] CAP_HI = (EXT_W)'(1) << (ppl_pkg::CAP_W - 2);
    localparam logic signed [EXT_W-1:0] CAP_LO = -CAP_HI;
    localparam logic signed [SUM_W-1:0] RND    = (SUM_W)'(1) << (FB - 1);

    // configuration registers
    logic                                r_reverse;
    logic signed [ppl_pkg::GAIN_W-1:0]   r_prop_gain;
    logic signed [ppl_pkg::GAIN_W-1:0]   r_deriv_gain;
    logic        [LW-1:0]                r_out_limit;

    // loop state
    logic        [AW-1:0]                r_prev_angle;
    logic                                r_primed;
    logic signed [PW-1:0]                r_accum;
    logic signed [ERR_W-1:0]             r_prev_err;

    // pipeline registers
    logic                                r_v1, r_v2, r_v3;
    logic signed [ppl_pkg::CAP_W-1:0]    r_err_c, r_derr_c;
    logic                                r_err_pos1, r_err_pos2;
    logic        [OW-1:0]                r_pos1, r_pos2, r_pos3;
    logic signed [PROD_W-1:0]            r_p_prod, r_d_prod;
    logic        [CW-1:0]                r_cmd;
    logic                                r_limited;

    // stage one signals
    logic        [AW-1:0]                in_angle;
    logic signed [TW-1:0]                in_target;
    logic signed [AW+1:0]                raw_step, wrap_step;
    logic signed [AW:0]                  step;
    logic signed [PW:0]                  pos_sum;
    logic signed [PW-1:0]                n_accum;
    logic signed [ERR_W-1:0]             n_err;
    logic signed [DIFF_W-1:0]            derr;
    logic signed [EXT_W-1:0]             err_x, derr_x;
    logic signed [ppl_pkg::CAP_W-1:0]    n_err_c, n_derr_c;
    logic                                advance, take;

    // stage three signals
    logic signed [PROD_W-1:0]            p_abs;
    logic        [PROD_W-1:0]            lim_scaled;
    logic signed [SUM_W-1:0]             pd_sum, pd_q;
    logic signed [SUM_W-1:0]             lim_pos, lim_neg;
    logic                                force_lim;
    logic        [CW-1:0]                n_cmd;
    logic                                n_limited;

    // flow control: every stage moves while the output slot is free or taken
    assign advance       = !r_v3 || m_axis_tready;
    assign s_axis_tready = advance;
    assign take          = s_axis_tvalid && advance;

    assign in_angle  = s_axis_tdata[AW-1:0];
    assign in_target = s_axis_tdata[AW+TW-1:AW];

    // angle unwrap, direction and saturating position update
    always_comb begin
        raw_step = $signed({2'b00, in_angle}) - $signed({2'b00, r_prev_angle});
        if (raw_step > HALF) begin
            wrap_step = raw_step - FULL;
        end else if (raw_step < -HALF) begin
            wrap_step = raw_step + FULL;
        end else begin
            wrap_step = raw_step;
        end
        step = r_reverse ? -wrap_step[AW:0] : wrap_step[AW:0];
        pos_sum = (PW+1)'(r_accum) + (PW+1)'(step);
        if (!r_primed) begin
            n_accum = r_accum;
        end else if (pos_sum[PW] != pos_sum[PW-1]) begin
            n_accum = pos_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else begin
            n_accum = pos_sum[PW-1:0];
        end
    end

    // error, error change and their caps
    always_comb begin
        n_err  = (ERR_W)'(in_target) - (ERR_W)'(n_accum);
        derr   = (DIFF_W)'(n_err) - (DIFF_W)'(r_prev_err);
        err_x  = (EXT_W)'(n_err);
        derr_x = (EXT_W)'(derr);
        if (err_x > CAP_HI) begin
            n_err_c = CAP_HI[ppl_pkg::CAP_W-1:0];
        end else if (err_x < CAP_LO) begin
            n_err_c = CAP_LO[ppl_pkg::CAP_W-1:0];
        end else begin
            n_err_c = err_x[ppl_pkg::CAP_W-1:0];
        end
        if (derr_x > CAP_HI) begin
            n_derr_c = CAP_HI[ppl_pkg::CAP_W-1:0];
        end else if (derr_x < CAP_LO) begin
            n_derr_c = CAP_LO[ppl_pkg::CAP_W-1:0];
        end else begin
            n_derr_c = derr_x[ppl_pkg::CAP_W-1:0];
        end
    end

    // forcing test, rounding and clamp
    always_comb begin
        p_abs      = r_p_prod[PROD_W-1] ? -r_p_prod : r_p_prod;
        lim_scaled = (PROD_W)'({r_out_limit, {FB{1'b0}}});
        force_lim  = (r_out_limit != '0) && (r_prop_gain != '0) &&
                     ($unsigned(p_abs) > lim_scaled);
        pd_sum     = (SUM_W)'(r_p_prod) + (SUM_W)'(r_d_prod) + RND;
        pd_q       = pd_sum >>> FB;
        lim_pos    = $signed((SUM_W)'(r_out_limit));
        lim_neg    = -lim_pos;
        n_limited  = 1'b1;
        if (force_lim) begin
            n_cmd = r_err_pos2 ? lim_pos[CW-1:0] : lim_neg[CW-1:0];
        end else if (pd_q > lim_pos) begin
            n_cmd = lim_pos[CW-1:0];
        end else if (pd_q < lim_neg) begin
            n_cmd = lim_neg[CW-1:0];
        end else begin
            n_cmd     = pd_q[CW-1:0];
            n_limited = 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse    <= 1'b0;
            r_prop_gain  <= '0;
            r_deriv_gain <= '0;
            r_out_limit  <= '0;
        end else if (i_cfg_we) begin
            unique case (ppl_pkg::t_cfg_idx'(i_cfg_addr))
                ppl_pkg::CFG_REVERSE_DIRECTION: r_reverse    <= i_cfg_wdata[0];
                ppl_pkg::CFG_PROP_GAIN:         r_prop_gain  <= i_cfg_wdata[ppl_pkg::GAIN_W-1:0];
                ppl_pkg::CFG_DERIV_GAIN:        r_deriv_gain <= i_cfg_wdata[ppl_pkg::GAIN_W-1:0];
                ppl_pkg::CFG_OUT_LIMIT:         r_out_limit  <= i_cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // loop state, updated on each sample transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_angle <= '0;
            r_primed     <= 1'b0;
            r_accum      <= '0;
            r_prev_err   <= '0;
        end else if (take) begin
            r_prev_angle <= in_angle;
            r_primed     <= 1'b1;
            r_accum      <= n_accum;
            r_prev_err   <= n_err;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_err_c    <= n_err_c;
            r_derr_c   <= n_derr_c;
            r_err_pos1 <= (n_err > 0);
            r_pos1     <= OW'(n_accum);
            r_p_prod   <= PROD_W'(r_prop_gain * r_err_c);
            r_d_prod   <= PROD_W'(r_deriv_gain * r_derr_c);
            r_err_pos2 <= r_err_pos1;
            r_pos2     <= r_pos1;
            r_cmd      <= n_cmd;
            r_limited  <= n_limited;
            r_pos3     <= r_pos2;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {r_pos3, r_cmd};
    assign m_axis_tuser  = r_limited;

endmodule
